// ===== src/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants of the LZSS stream decompressor.
// ----------------------------------------------------------------------------
package lsd_pkg;

    // default history depth, as log2 of the byte count
    localparam int LSD_HISTORY_BITS = 16;

    // stream widths
    localparam int LSD_S_TDATA_W = 8;
    localparam int LSD_S_TUSER_W = 1;
    localparam int LSD_M_TDATA_W = 72;   // 69 payload bits, padded to bytes
    localparam int LSD_M_TUSER_W = 2;

    localparam int LSD_CONSUMED_W = 26;
    localparam int LSD_PRODUCED_W = 34;

    // token decode constants
    localparam logic [6:0] LSD_SPAN_MASK  = 7'h7F;
    localparam logic [6:0] LSD_SPAN_LIMIT = 7'd31;
    localparam logic [4:0] LSD_THR_CAP    = 5'd19;
    localparam logic [2:0] LSD_SHIFT_TOP  = 3'd7;
    localparam logic [9:0] LSD_MIN_MATCH  = 10'd3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CNT2   = 3'd1,
        PH_CNT1   = 3'd2,
        PH_CNT0   = 3'd3,
        PH_ITEM   = 3'd4,
        PH_TOKLO  = 3'd5,
        PH_COPY   = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    // one result item, per processed tick
    typedef struct packed {
        logic                      byte_taken;
        logic                      plain_valid;
        logic [7:0]                plain_byte;
        logic                      finished;
        logic                      bad_offset;
        logic [LSD_CONSUMED_W-1:0] bytes_consumed;
        logic [LSD_PRODUCED_W-1:0] bytes_produced;
    } t_result;

endpackage

// ===== src/lsd_hist_ram.sv =====
// ----------------------------------------------------------------------------
// lsd_hist_ram
// History byte RAM: one write port, one registered read port with
// write-to-read bypass on an address match in the same cycle.
// ----------------------------------------------------------------------------
module lsd_hist_ram #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [7:0]           i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [7:0]           o_rdata
);

    logic [7:0] r_mem [(1 << ADDR_BITS)];
    logic [7:0] r_rd;
    logic [7:0] r_byp_data;
    logic       r_byp;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd       <= r_mem[i_raddr];
            r_byp_data <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_re) begin
            r_byp <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_byp ? r_byp_data : r_rd;

endmodule

// ===== src/lsd_core.sv =====
// ----------------------------------------------------------------------------
// lsd_core
// Decoder state machine: one tick of header/flag/token parsing or match
// copy per step, with history write and next-tick read prefetch.
// ----------------------------------------------------------------------------
module lsd_core
    import lsd_pkg::*;
#(
    parameter int HISTORY_BITS = LSD_HISTORY_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic                    i_offered,
    input  logic [7:0]              i_byte,
    input  logic [7:0]              i_rdata,
    output logic                    o_we,
    output logic [HISTORY_BITS-1:0] o_waddr,
    output logic [7:0]              o_wdata,
    output logic                    o_re,
    output logic [HISTORY_BITS-1:0] o_raddr,
    output t_result                 o_result
);

    localparam int FILL_W = HISTORY_BITS + 1;
    localparam logic [FILL_W-1:0] HIST_SIZE = FILL_W'(1) << HISTORY_BITS;

    t_phase                    r_phase, n_phase;
    logic [2:0]                r_split, n_split;
    logic [1:0]                r_lshift, n_lshift;
    logic [4:0]                r_thr, n_thr;
    logic [23:0]               r_items, n_items;
    logic [8:0]                r_flags, n_flags;
    logic [7:0]                r_tok_hi, n_tok_hi;
    logic [15:0]               r_dist, n_dist;
    logic [9:0]                r_copy, n_copy;
    logic [HISTORY_BITS-1:0]   r_wp, n_wp;
    logic [FILL_W-1:0]         r_filled, n_filled;
    logic [LSD_CONSUMED_W-1:0] r_consumed, n_consumed;
    logic [LSD_PRODUCED_W-1:0] r_produced, n_produced;

    logic        w_last_item;
    logic        w_copy_end;
    logic        w_flag_load;
    logic        w_bad;
    logic        w_emit;
    logic [7:0]  w_emit_byte;
    logic [15:0] w_token;
    logic [6:0]  w_span;
    logic [6:0]  w_idx;
    logic [9:0]  w_len;
    logic [6:0]  w_hdr_span;

    assign w_last_item = (r_items == 24'd0);
    assign w_copy_end  = (r_copy == 10'd1);
    assign w_flag_load = (r_flags <= 9'd1);
    assign w_bad       = (r_dist == 16'd0) || (17'(r_dist) > 17'(r_filled));

    // token decode
    assign w_token    = {r_tok_hi, i_byte};
    assign w_span     = LSD_SPAN_MASK >> r_split;
    assign w_idx      = w_token[6:0] & w_span;
    assign w_hdr_span = LSD_SPAN_MASK >> i_byte[2:0];

    always_comb begin
        if (w_idx <= 7'(r_thr)) begin
            w_len = 10'(w_idx) + LSD_MIN_MATCH;
        end else begin
            w_len = 10'(r_thr) + (10'(w_idx - 7'(r_thr)) << r_lshift) + LSD_MIN_MATCH;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            unique case (r_phase)
                PH_COPY: begin
                    if (w_copy_end) begin
                        n_phase = w_last_item ? PH_DONE : PH_ITEM;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                PH_HEADER: if (i_offered) n_phase = PH_CNT2;
                PH_CNT2:   if (i_offered) n_phase = PH_CNT1;
                PH_CNT1:   if (i_offered) n_phase = PH_CNT0;
                PH_CNT0:   if (i_offered) n_phase = PH_ITEM;
                PH_ITEM: begin
                    if (i_offered && !w_flag_load) begin
                        if (r_flags[0]) begin
                            n_phase = w_last_item ? PH_DONE : PH_ITEM;
                        end else begin
                            n_phase = PH_TOKLO;
                        end
                    end
                end
                PH_TOKLO:  if (i_offered) n_phase = PH_COPY;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_split    = r_split;
        n_lshift   = r_lshift;
        n_thr      = r_thr;
        n_items    = r_items;
        n_flags    = r_flags;
        n_tok_hi   = r_tok_hi;
        n_dist     = r_dist;
        n_copy     = r_copy;
        n_consumed = r_consumed;
        w_emit      = 1'b0;
        w_emit_byte = 8'd0;
        o_result    = '0;

        if (r_phase == PH_COPY) begin
            o_result.bad_offset = w_bad;
            w_emit      = 1'b1;
            w_emit_byte = w_bad ? 8'd0 : i_rdata;
            n_copy      = r_copy - 10'd1;
            if (w_copy_end && !w_last_item) begin
                n_items = r_items - 24'd1;
            end
        end else if (r_phase != PH_DONE && i_offered) begin
            o_result.byte_taken = 1'b1;
            n_consumed = r_consumed + LSD_CONSUMED_W'(1);
            unique case (r_phase)
                PH_HEADER: begin
                    n_split  = i_byte[2:0];
                    n_lshift = i_byte[4:3];
                    n_thr    = (w_hdr_span < LSD_SPAN_LIMIT) ? 5'(w_hdr_span >> 1)
                                                             : LSD_THR_CAP;
                end
                PH_CNT2: n_items = {i_byte, 16'd0};
                PH_CNT1: n_items = r_items | {8'd0, i_byte, 8'd0};
                PH_CNT0: begin
                    n_items = r_items | {16'd0, i_byte};
                    n_flags = 9'd0;
                end
                PH_ITEM: begin
                    if (w_flag_load) begin
                        n_flags = {1'b1, i_byte};
                    end else begin
                        n_flags = r_flags >> 1;
                        if (r_flags[0]) begin
                            w_emit      = 1'b1;
                            w_emit_byte = i_byte;
                            if (!w_last_item) begin
                                n_items = r_items - 24'd1;
                            end
                        end else begin
                            n_tok_hi = i_byte;
                        end
                    end
                end
                PH_TOKLO: begin
                    n_dist = w_token >> (LSD_SHIFT_TOP - r_split);
                    n_copy = w_len;
                end
                PH_COPY, PH_DONE: begin
                end
            endcase
        end

        if (w_emit) begin
            n_wp       = r_wp + HISTORY_BITS'(1);
            n_filled   = (r_filled < HIST_SIZE) ? r_filled + FILL_W'(1) : r_filled;
            n_produced = r_produced + LSD_PRODUCED_W'(1);
        end else begin
            n_wp       = r_wp;
            n_filled   = r_filled;
            n_produced = r_produced;
        end

        o_result.plain_valid    = w_emit;
        o_result.plain_byte     = w_emit_byte;
        o_result.finished       = (n_phase == PH_DONE);
        o_result.bytes_consumed = n_consumed;
        o_result.bytes_produced = n_produced;
    end

    // history write now, prefetch of the byte the next copy tick needs
    assign o_we    = i_step && w_emit;
    assign o_waddr = r_wp;
    assign o_wdata = w_emit_byte;
    assign o_re    = i_step;
    assign o_raddr = n_wp - n_dist[HISTORY_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_split    <= '0;
            r_lshift   <= '0;
            r_thr      <= '0;
            r_items    <= '0;
            r_flags    <= '0;
            r_tok_hi   <= '0;
            r_dist     <= '0;
            r_copy     <= '0;
            r_wp       <= '0;
            r_filled   <= '0;
            r_consumed <= '0;
            r_produced <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_split    <= n_split;
            r_lshift   <= n_lshift;
            r_thr      <= n_thr;
            r_items    <= n_items;
            r_flags    <= n_flags;
            r_tok_hi   <= n_tok_hi;
            r_dist     <= n_dist;
            r_copy     <= n_copy;
            r_wp       <= n_wp;
            r_filled   <= n_filled;
            r_consumed <= n_consumed;
            r_produced <= n_produced;
        end
    end

endmodule

// ===== src/lzss_stream_decompressor.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS decompressor driven one tick per input item over a stream channel.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the slave channel is one decoder tick: tuser says whether a
//   compressed byte is offered, tdata carries it. Each tick yields exactly
//   one item on the master channel with the tick's status: whether the byte
//   was taken, an emitted plain byte (if any), the bad offset flag, and the
//   running consumed/produced counts. tlast is the finished flag and stays
//   high on every item after the last decoded item.
//   During a match copy a tick emits one byte from history and ignores the
//   offered byte, so the sender must offer it again on a later tick.
//   Path: an accepted item is held in the input register, then its result
//   in the result register, which drives the master channel.
//   Throughput: one item per cycle unless the receiver stalls; the history
//   RAM read for the next copy tick is issued on the edge that finishes the
//   current tick, with a bypass when it hits the byte being written.
//   Reset: synchronous, active low; the decoder waits for a header byte,
//   counters are zero. History RAM content is not cleared: a copy from an
//   unwritten location is always flagged as a bad offset and emits zero.
//   Stall: while the receiver holds tready low the result holds; the input
//   register still takes one item, then tready on the slave side drops.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor
    import lsd_pkg::*;
#(
    parameter int HISTORY_BITS = LSD_HISTORY_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // slave side
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [LSD_S_TDATA_W-1:0] i_s_tdata,   // [7:0] packed_byte
    input  logic [LSD_S_TUSER_W-1:0] i_s_tuser,   // [0] byte_offered
    // master side
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // [0] byte_taken, [8:1] plain_byte, [34:9] bytes_consumed,
    // [68:35] bytes_produced, [71:69] zero
    output logic [LSD_M_TDATA_W-1:0] o_m_tdata,
    output logic [LSD_M_TUSER_W-1:0] o_m_tuser,   // [0] plain_valid, [1] bad_offset
    output logic                     o_m_tlast    // finished
);

    // input register
    logic       r_in_valid;
    logic       r_in_offered;
    logic [7:0] r_in_byte;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    logic       w_step;
    t_result    w_result;

    // history RAM hookup
    logic                    w_we;
    logic [HISTORY_BITS-1:0] w_waddr;
    logic [7:0]              w_wdata;
    logic                    w_re;
    logic [HISTORY_BITS-1:0] w_raddr;
    logic [7:0]              w_rdata;

    // a tick runs when an item is held and the result slot is free
    assign w_step     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_offered <= i_s_tuser[0];
            r_in_byte    <= i_s_tdata;
        end
    end

    lsd_core #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_offered (r_in_offered),
        .i_byte    (r_in_byte),
        .i_rdata   (w_rdata),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wdata   (w_wdata),
        .o_re      (w_re),
        .o_raddr   (w_raddr),
        .o_result  (w_result)
    );

    lsd_hist_ram #(
        .ADDR_BITS (HISTORY_BITS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out.bytes_produced, r_out.bytes_consumed,
                         r_out.plain_byte, r_out.byte_taken};
    assign o_m_tuser  = {r_out.bad_offset, r_out.plain_valid};
    assign o_m_tlast  = r_out.finished;

endmodule

// ===== src/lsd_checker.sv =====
// ----------------------------------------------------------------------------
// lsd_checker
// Port-level checks of the decompressor's result stream.
// ----------------------------------------------------------------------------
module lsd_checker
    import lsd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [LSD_M_TDATA_W-1:0] o_m_tdata,
    input  logic [LSD_M_TUSER_W-1:0] o_m_tuser,
    input  logic                     o_m_tlast
);

    logic                      w_out_hs;
    logic                      r_seen;
    logic                      r_done;
    logic [LSD_CONSUMED_W-1:0] r_cons;
    logic [LSD_PRODUCED_W-1:0] r_prod;

    assign w_out_hs = o_m_tvalid && i_m_tready;

    // last delivered counts and finish state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_done <= 1'b0;
            r_cons <= '0;
            r_prod <= '0;
        end else if (w_out_hs) begin
            r_seen <= 1'b1;
            r_done <= r_done || o_m_tlast;
            r_cons <= o_m_tdata[34:9];
            r_prod <= o_m_tdata[68:35];
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // counters step by the flags of each delivered item
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_hs && r_seen |->
            o_m_tdata[34:9] == r_cons + LSD_CONSUMED_W'(o_m_tdata[0])
            && o_m_tdata[68:35] == r_prod + LSD_PRODUCED_W'(o_m_tuser[0]))
        else $error("running counts do not follow taken/valid flags");

    // bad offset only on an emitted zero byte; no plain byte without valid
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[1] || !o_m_tuser[0]) |->
            o_m_tdata[8:1] == 8'd0 && !(o_m_tuser[1] && !o_m_tuser[0]))
        else $error("bad offset or idle tick with nonzero byte");

    // once finished, the decoder stays quiet
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_hs && r_done |-> o_m_tlast && !o_m_tdata[0] && !o_m_tuser[0])
        else $error("activity after finish");

endmodule

bind lzss_stream_decompressor lsd_checker u_lsd_checker (.*);
